>>> rtl/core/bsa_pkg.sv
// Shared types and constants for the ascending block sorter.
// No dependencies; every other file in rtl/core imports this package.
package bsa_pkg;

   localparam int WORD_W      = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One word on its way from the front end to the sorting cells.
   typedef struct packed {
      logic signed [WORD_W-1:0] value;
      logic                     block_end;
   } bsa_word_type;

endpackage

>>> rtl/core/block_sorter_ascending.sv
// Ascending block sorter. Takes BLOCK_SIZE signed 32-bit words and returns them smallest
// first, one word per response, with rsp_last on the final word. The sorting cells insert
// one word per cycle while words are available and then shift the block out one word per
// cycle while rsp_ready is high; the cell row holds one block at a time. A four-word queue
// ahead of the cells takes the first words of the next block while the current one drains.
module block_sorter_ascending #(
   parameter int BLOCK_SIZE = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [bsa_pkg::WORD_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [bsa_pkg::WORD_W-1:0] rsp_sorted_value,
   output logic                              rsp_last
);
   import bsa_pkg::*;

   logic         push_valid;
   logic         push_ready;
   bsa_word_type push_word;
   logic         pop_valid;
   logic         pop_ready;
   bsa_word_type pop_word;

   bsa_front #(
      .BLOCK_SIZE(BLOCK_SIZE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_word  (push_word)
   );

   bsa_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_word  (push_word),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_word   (pop_word)
   );

   bsa_cells #(
      .BLOCK_SIZE(BLOCK_SIZE)
   ) u_cells (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_word         (pop_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last         (rsp_last)
   );

endmodule

>>> rtl/core/bsa_front.sv
// Front end of the block sorter: accepts input words and marks the final word of each block.
// Depends on bsa_pkg.
module bsa_front #(
   parameter int BLOCK_SIZE = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [bsa_pkg::WORD_W-1:0] req_value,
   output logic                           push_valid,
   input  logic                           push_ready,
   output bsa_pkg::bsa_word_type          push_word
);
   import bsa_pkg::*;

   localparam int CNT_W = $clog2(BLOCK_SIZE);

   logic [CNT_W-1:0] load_count_ff;
   logic [CNT_W-1:0] load_count_in;
   logic             at_end;
   logic             accept;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;
   assign at_end     = (load_count_ff == CNT_W'(BLOCK_SIZE - 1));

   assign push_word.value     = req_value;
   assign push_word.block_end = at_end;

   always_comb begin
      load_count_in = load_count_ff;
      if (accept) begin
         load_count_in = at_end ? '0 : load_count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
      end else begin
         load_count_ff <= load_count_in;
      end
   end

endmodule

>>> rtl/core/bsa_fifo.sv
// Short word queue between the front end and the sorting cells.
// Depends on bsa_pkg for the word type and queue depth.
module bsa_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  bsa_pkg::bsa_word_type push_word,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output bsa_pkg::bsa_word_type pop_word
);
   import bsa_pkg::*;

   bsa_word_type      mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic              push_fire;
   logic              pop_fire;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_word   = mem_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      unique case ({push_fire, pop_fire})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push_fire) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop_fire) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

endmodule

>>> rtl/core/bsa_cells.sv
// Back end of the block sorter: a row of insertion cells that keeps the block in order
// and then shifts it out smallest first. Depends on bsa_pkg.
module bsa_cells #(
   parameter int BLOCK_SIZE = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              pop_valid,
   output logic                              pop_ready,
   input  bsa_pkg::bsa_word_type             pop_word,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [bsa_pkg::WORD_W-1:0] rsp_sorted_value,
   output logic                              rsp_last
);
   import bsa_pkg::*;

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

   state_type                state_ff;
   state_type                state_in;
   logic signed [WORD_W-1:0] cells_ff [BLOCK_SIZE];
   logic signed [WORD_W-1:0] cells_in [BLOCK_SIZE];
   logic [BLOCK_SIZE-1:0]    occ_ff;
   logic [BLOCK_SIZE-1:0]    occ_in;
   logic [BLOCK_SIZE-1:0]    place;

   assign pop_ready        = (state_ff == ST_LOAD);
   assign rsp_valid        = (state_ff == ST_DRAIN);
   assign rsp_sorted_value = cells_ff[0];
   assign rsp_last         = !occ_ff[1];

   // A cell takes part in the insertion when it is empty or holds a larger value.
   // Because the row stays sorted, the cells that do form a contiguous upper range.
   always_comb begin
      for (int i = 0; i < BLOCK_SIZE; i++) begin
         place[i] = !occ_ff[i] || (pop_word.value < cells_ff[i]);
      end
   end

   always_comb begin
      state_in = state_ff;
      occ_in   = occ_ff;
      cells_in = cells_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (pop_valid) begin
               if (place[0]) begin
                  cells_in[0] = pop_word.value;
               end
               for (int i = 1; i < BLOCK_SIZE; i++) begin
                  if (place[i]) begin
                     cells_in[i] = place[i-1] ? cells_ff[i-1] : pop_word.value;
                  end
               end
               occ_in = {occ_ff[BLOCK_SIZE-2:0], 1'b1};
               if (pop_word.block_end) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (rsp_ready) begin
               for (int i = 0; i < BLOCK_SIZE - 1; i++) begin
                  cells_in[i] = cells_ff[i+1];
               end
               occ_in = {1'b0, occ_ff[BLOCK_SIZE-1:1]};
               if (!occ_ff[1]) begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      cells_ff <= cells_in;
      if (reset) begin
         state_ff <= ST_LOAD;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
      end
   end

endmodule

>>> rtl/core/bsa_checker.sv
// Port-level checks for the ascending block sorter, bound to the top level.
// Depends on bsa_pkg and on the ports of block_sorter_ascending.
module bsa_checker #(
   parameter int BLOCK_SIZE = 8
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic signed [bsa_pkg::WORD_W-1:0] req_value,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [bsa_pkg::WORD_W-1:0] rsp_sorted_value,
   input logic                              rsp_last
);
   import bsa_pkg::*;

   localparam int CNT_W = $clog2(BLOCK_SIZE);

   logic [CNT_W-1:0]         out_cnt_ff;
   logic                     mid_ff;
   logic signed [WORD_W-1:0] prev_ff;
   logic                     rsp_fire;

   assign rsp_fire = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (rsp_fire) begin
         prev_ff <= rsp_sorted_value;
      end
      if (reset) begin
         out_cnt_ff <= '0;
         mid_ff     <= 1'b0;
      end else if (rsp_fire) begin
         out_cnt_ff <= rsp_last ? '0 : out_cnt_ff + CNT_W'(1);
         mid_ff     <= !rsp_last;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sorted_value) && $stable(rsp_last))
      else $error("response word changed or dropped while stalled");

   a_last_position: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> (rsp_last == (out_cnt_ff == CNT_W'(BLOCK_SIZE - 1))))
      else $error("last flag not on the final word of a block");

   a_ascending: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && mid_ff |-> (rsp_sorted_value >= prev_ff))
      else $error("response words out of ascending order");

   a_req_known: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !$isunknown(req_value))
      else $error("accepted request word has unknown bits");

endmodule

bind block_sorter_ascending bsa_checker #(
   .BLOCK_SIZE(BLOCK_SIZE)
) u_bsa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_value        (req_value),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_sorted_value (rsp_sorted_value),
   .rsp_last         (rsp_last)
);
